// ----- rtl/core/d2i_pkg.sv -----
// Package: rounding-mode codes, payload widths and constants for the double-to-int64 converter.
`timescale 1ns / 1ps
package d2i_pkg;
  localparam int DATA_W = 64;
  localparam int MODE_W = 3;
  localparam int IN_TDATA_W = 72;
  localparam int OUT_TDATA_W = 72;

  localparam logic [MODE_W-1:0] MODE_RNE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RTZ = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RDN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RUP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RMM = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DYN = 3'd7;

  localparam logic [DATA_W-1:0] INT64_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] INT64_BOTTOM = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] int_result;
    logic invalid_flag;
    logic inexact_flag;
    logic illegal_mode_flag;
  } d2i_res_t;
endpackage

// ----- rtl/core/d2i_core.sv -----
// Combinational core: decode, align, round and saturate one double.
`timescale 1ns / 1ps
module d2i_core (
  input  logic                    command,
  input  logic [63:0]             operand_bits,
  input  logic [2:0]              mode,
  output d2i_pkg::d2i_res_t       res
);
  import d2i_pkg::*;

  logic        neg;
  logic [10:0] ex;
  logic [51:0] frac;
  logic [52:0] sig;
  logic [11:0] ex_eff;
  logic [63:0] mag_sh;
  logic [52:0] mag_r;
  logic [63:0] mag;
  logic        big, guard, sticky, inc, inexact;
  logic [5:0]  sh;
  logic [52:0] rem;
  logic [52:0] half;

  always_comb begin
    neg  = operand_bits[63];
    ex   = operand_bits[62:52];
    frac = operand_bits[51:0];
    sig  = {(ex != 11'd0), frac};
    ex_eff = (ex != 11'd0) ? {1'b0, ex} : 12'd1;
    big = 1'b0; guard = 1'b0; sticky = 1'b0; inc = 1'b0;
    mag_sh = '0; mag_r = '0; sh = '0; rem = '0; half = '0;
    if (ex_eff >= 12'd1075) begin
      if (ex_eff > 12'd1086) big = (sig != '0);
      else mag_sh = {11'd0, sig} << (ex_eff - 12'd1075);
      mag = mag_sh;
    end else begin
      if (ex_eff <= 12'd1011) begin
        sticky = (sig != '0);
      end else begin
        sh = 6'(12'd1075 - ex_eff);
        mag_r = sig >> sh;
        rem   = sig & ~({53{1'b1}} << sh);
        half  = 53'd1 << (sh - 6'd1);
        guard = (rem & half) != '0;
        sticky = (rem & (half - 53'd1)) != '0;
      end
      case (mode)
        MODE_RNE: inc = guard && (sticky || mag_r[0]);
        MODE_RTZ: inc = 1'b0;
        MODE_RDN: inc = neg && (guard || sticky);
        MODE_RUP: inc = !neg && (guard || sticky);
        default:  inc = guard;
      endcase
      mag = {11'd0, mag_r} + {63'd0, inc};
    end
    inexact = guard || sticky;

    res = '0;
    if (mode > MODE_RMM) begin
      res.illegal_mode_flag = 1'b1;
    end else if (ex == 11'h7FF) begin
      res.invalid_flag = 1'b1;
      if (frac != '0 || !neg) res.int_result = command ? '1 : INT64_TOP;
      else res.int_result = command ? '0 : INT64_BOTTOM;
    end else if (command) begin
      if (neg) begin
        if (big || mag != '0) res.invalid_flag = 1'b1;
        else res.inexact_flag = inexact;
      end else if (big) begin
        res.int_result = '1; res.invalid_flag = 1'b1;
      end else begin
        res.int_result = mag; res.inexact_flag = inexact;
      end
    end else if (neg) begin
      if (big || mag > INT64_BOTTOM) begin
        res.int_result = INT64_BOTTOM; res.invalid_flag = 1'b1;
      end else begin
        res.int_result = 64'd0 - mag; res.inexact_flag = inexact;
      end
    end else begin
      if (big || mag > INT64_TOP) begin
        res.int_result = INT64_TOP; res.invalid_flag = 1'b1;
      end else begin
        res.int_result = mag; res.inexact_flag = inexact;
      end
    end
  end
endmodule

// ----- rtl/core/double_to_int64_convert.sv -----
// Top level: double to int64/uint64 converter with input and result registers.
// Path: each transfer is captured in the input register, then its result in the result register.
// Throughput: one transfer per cycle; the result register and input register
// advance together whenever the result side is free or being drained.
// Reset (rst, synchronous, active high) clears valid bits and sets the
// dynamic rounding mode to RNE.
`timescale 1ns / 1ps
module double_to_int64_convert (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [d2i_pkg::MODE_W-1:0]         cfg_wr_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] command, [64:1] operand_bits, [67:65] rounding_field
  input  logic [d2i_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [63:0] int_result, [64] invalid, [65] inexact, [66] illegal
  output logic [d2i_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import d2i_pkg::*;

  logic [2:0]  dyn_mode;
  logic        in_valid;
  logic        in_cmd;
  logic [63:0] in_op;
  logic [2:0]  in_rm;
  logic [2:0]  eff_mode;
  d2i_res_t    core_res;
  d2i_res_t    out_res;
  logic        adv;

  // pipeline moves when result slot is empty or being taken
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) dyn_mode <= MODE_RNE;
    else if (cfg_wr_en) dyn_mode <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_cmd  <= s_tdata[0];
      in_op   <= s_tdata[64:1];
      in_rm   <= s_tdata[67:65];
      out_res <= core_res;
    end
  end

  // dynamic mode resolved at the register stage
  assign eff_mode = (in_rm == MODE_DYN) ? dyn_mode : in_rm;

  d2i_core u_core (
    .command      (in_cmd),
    .operand_bits (in_op),
    .mode         (eff_mode),
    .res          (core_res)
  );

  assign m_tdata = {5'd0, out_res.illegal_mode_flag, out_res.inexact_flag,
                    out_res.invalid_flag, out_res.int_result};
endmodule

// ----- rtl/core/d2i_checker.sv -----
// Port checker for the converter, bound to the top level.
`timescale 1ns / 1ps
module d2i_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready) else $error("accepted while stalled");
  a_ill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[66] |-> m_tdata[65:0] == 66'd0) else $error("illegal payload");
  a_inv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> !m_tdata[65]) else $error("invalid and inexact");
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
endmodule

bind double_to_int64_convert d2i_checker u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata)
);
